// ===== src/mups_pkg.sv =====
`timescale 1ns / 1ps

package mups_pkg;

    localparam int BYTE_W              = 8;
    localparam int POS_W               = 32;
    localparam int LANES               = 16;
    localparam int LANE_IDX_W          = 4;
    localparam int LEN_W               = 5;
    localparam int CFG_DATA_W          = 64;
    localparam int CFG_ADDR_W          = 6;
    localparam int DEFAULT_MAX_PATTERN = 16;

    localparam logic [POS_W-1:0]      POS_MAX      = '1;
    localparam logic [CFG_DATA_W-1:0] MASK_RESET   = '1;
    localparam logic [LEN_W-1:0]      LENGTH_RESET = LEN_W'(1);

    typedef enum logic [2:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_MASK_LOW       = 3'd2,
        REG_MASK_HIGH      = 3'd3,
        REG_PATTERN_LENGTH = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_AMBIGUOUS = 2'd2,
        ST_BAD       = 2'd3
    } status_t;

    // Pattern and mask as 16 byte lanes, lane k in bits 8k+7..8k.
    typedef struct packed {
        logic [LANES*BYTE_W-1:0] pattern;
        logic [LANES*BYTE_W-1:0] mask;
        logic [LEN_W-1:0]        length;
    } cfg_t;

    typedef struct packed {
        logic len_ok;   // 1 <= length <= MAX_PATTERN
        logic enough;   // at least length bytes seen in this buffer
        logic hit;      // masked window compare passes
    } match_t;

endpackage

// ===== src/mups_in_if.sv =====
`timescale 1ns / 1ps

interface mups_in_if;
    logic                           valid;
    logic                           ready;
    logic [mups_pkg::BYTE_W-1:0]    data_byte;
    logic                           last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/mups_out_if.sv =====
`timescale 1ns / 1ps

interface mups_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     scan_status;
    logic [mups_pkg::POS_W-1:0]     match_offset;

    modport source (output valid, output scan_status, output match_offset, input ready);
    modport sink   (input valid, input scan_status, input match_offset, output ready);
endinterface

// ===== src/mups_regs.sv =====
`timescale 1ns / 1ps

module mups_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mups_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mups_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mups_pkg::CFG_DATA_W-1:0]     prdata,
    output mups_pkg::cfg_t                      cfg
);

    logic [mups_pkg::CFG_DATA_W-1:0] pattern_low_reg, pattern_low_next;
    logic [mups_pkg::CFG_DATA_W-1:0] pattern_high_reg, pattern_high_next;
    logic [mups_pkg::CFG_DATA_W-1:0] mask_low_reg, mask_low_next;
    logic [mups_pkg::CFG_DATA_W-1:0] mask_high_reg, mask_high_next;
    logic [mups_pkg::LEN_W-1:0]      length_reg, length_next;
    logic                            wr_en;
    mups_pkg::reg_idx_t              idx;

    // 64-bit registers sit at 8-byte strides
    assign idx   = mups_pkg::reg_idx_t'(paddr[mups_pkg::CFG_ADDR_W-1:3]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        pattern_low_next  = pattern_low_reg;
        pattern_high_next = pattern_high_reg;
        mask_low_next     = mask_low_reg;
        mask_high_next    = mask_high_reg;
        length_next       = length_reg;
        if (wr_en)
        begin
            case (idx)
                mups_pkg::REG_PATTERN_LOW:    pattern_low_next  = pwdata;
                mups_pkg::REG_PATTERN_HIGH:   pattern_high_next = pwdata;
                mups_pkg::REG_MASK_LOW:       mask_low_next     = pwdata;
                mups_pkg::REG_MASK_HIGH:      mask_high_next    = pwdata;
                mups_pkg::REG_PATTERN_LENGTH: length_next = pwdata[mups_pkg::LEN_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            mups_pkg::REG_PATTERN_LOW:    prdata = pattern_low_reg;
            mups_pkg::REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            mups_pkg::REG_MASK_LOW:       prdata = mask_low_reg;
            mups_pkg::REG_MASK_HIGH:      prdata = mask_high_reg;
            mups_pkg::REG_PATTERN_LENGTH: prdata = mups_pkg::CFG_DATA_W'(length_reg);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            mask_low_reg     <= mups_pkg::MASK_RESET;
            mask_high_reg    <= mups_pkg::MASK_RESET;
            length_reg       <= mups_pkg::LENGTH_RESET;
        end
        else
        begin
            pattern_low_reg  <= pattern_low_next;
            pattern_high_reg <= pattern_high_next;
            mask_low_reg     <= mask_low_next;
            mask_high_reg    <= mask_high_next;
            length_reg       <= length_next;
        end
    end

    assign cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign cfg.mask    = {mask_high_reg, mask_low_reg};
    assign cfg.length  = length_reg;

endmodule

// ===== src/mups_window.sv =====
`timescale 1ns / 1ps

module mups_window
#(
    parameter int MAX_PATTERN = mups_pkg::DEFAULT_MAX_PATTERN
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  logic [mups_pkg::BYTE_W-1:0]             data_byte,
    input  logic                                    last_byte,
    output logic [MAX_PATTERN*mups_pkg::BYTE_W-1:0] window,
    output logic [mups_pkg::POS_W-1:0]              position
);

    localparam int WIN_W = MAX_PATTERN * mups_pkg::BYTE_W;

    logic [WIN_W-1:0]              window_reg, window_next;
    logic [mups_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                          restart_reg, restart_next;
    logic [WIN_W-1:0]              base;

    // Byte 0 is the newest. After a last byte the next buffer shifts in
    // from an all-zero window and a count of zero.
    assign base = restart_reg ? '0 : window_reg;

    always_comb
    begin
        window_next  = window_reg;
        pos_next     = pos_reg;
        restart_next = restart_reg;
        if (load)
        begin
            window_next  = (base << mups_pkg::BYTE_W) | WIN_W'(data_byte);
            restart_next = last_byte;
            if (restart_reg)
                pos_next = mups_pkg::POS_W'(1);
            else if (pos_reg != mups_pkg::POS_MAX)
                pos_next = pos_reg + mups_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= '0;
            pos_reg     <= '0;
            restart_reg <= 1'b0;
        end
        else
        begin
            window_reg  <= window_next;
            pos_reg     <= pos_next;
            restart_reg <= restart_next;
        end
    end

    assign window   = window_reg;
    assign position = pos_reg;

endmodule

// ===== src/mups_match.sv =====
`timescale 1ns / 1ps

module mups_match
#(
    parameter int MAX_PATTERN = mups_pkg::DEFAULT_MAX_PATTERN
)
(
    input  logic [MAX_PATTERN*mups_pkg::BYTE_W-1:0] window,
    input  logic [mups_pkg::POS_W-1:0]              position,
    input  mups_pkg::cfg_t                          cfg,
    output mups_pkg::match_t                        result
);

    // Window byte w lines up with pattern lane (length-1-w); all bytes in parallel.
    always_comb
    begin
        logic [mups_pkg::LEN_W-1:0]      lane5;
        logic [mups_pkg::LANE_IDX_W-1:0] lane;
        logic [mups_pkg::BYTE_W-1:0]     diff;
        logic                            miss;
        miss = 1'b0;
        for (int w = 0; w < MAX_PATTERN; w++)
        begin
            lane5 = cfg.length - mups_pkg::LEN_W'(1) - mups_pkg::LEN_W'(w);
            lane  = lane5[mups_pkg::LANE_IDX_W-1:0];
            diff  = window[w*mups_pkg::BYTE_W +: mups_pkg::BYTE_W]
                  ^ cfg.pattern[lane*mups_pkg::BYTE_W +: mups_pkg::BYTE_W];
            if ((mups_pkg::LEN_W'(w) < cfg.length)
                && ((diff & cfg.mask[lane*mups_pkg::BYTE_W +: mups_pkg::BYTE_W]) != '0))
                miss = 1'b1;
        end
        result.hit    = !miss;
        result.len_ok = (cfg.length != '0)
                     && (cfg.length <= mups_pkg::LEN_W'(MAX_PATTERN));
        result.enough = position >= mups_pkg::POS_W'(cfg.length);
    end

endmodule

// ===== src/masked_unique_pattern_scan.sv =====
`timescale 1ns / 1ps
// A last byte is taken into the window and the input register stage, then its result is registered.
// Throughput: one byte per cycle; the input only stalls when a last byte waits behind
//   an untaken result in the output register.
// Reset (rst_n low, async): scan state and window cleared, pattern/mask to reset values
//   (mask all ones), pattern length 1, no item in flight, no result pending.

module masked_unique_pattern_scan
#(
    parameter int MAX_PATTERN = mups_pkg::DEFAULT_MAX_PATTERN
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    mups_in_if.sink                             in_ch,
    mups_out_if.source                          out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mups_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mups_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mups_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int WIN_W = MAX_PATTERN * mups_pkg::BYTE_W;

    mups_pkg::cfg_t                 cfg;
    mups_pkg::match_t               match;
    logic [WIN_W-1:0]               window;
    logic [mups_pkg::POS_W-1:0]     position;

    // Input register stage: the window/count already hold the byte, these
    // flags say a byte is waiting for its compare.
    logic                           a_valid_reg, a_valid_next;
    logic                           a_last_reg, a_last_next;

    // Per-buffer scan state
    logic [1:0]                     tally_reg, tally_next;
    logic [mups_pkg::POS_W-1:0]     first_reg, first_next;

    // Result register
    logic                           out_valid_reg, out_valid_next;
    mups_pkg::status_t              status_reg, status_next;
    logic [mups_pkg::POS_W-1:0]     offset_reg, offset_next;

    logic                           stall;
    logic                           accept;
    logic                           process;
    logic                           hit_now;
    logic [1:0]                     tally_eff;
    logic [mups_pkg::POS_W-1:0]     first_eff;

    assign pready = 1'b1;

    mups_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Only a last byte needs the output register, so only a waiting last byte can cause a stall.
    assign stall   = a_valid_reg && a_last_reg && out_valid_reg && !out_ch.ready;
    assign in_ch.ready = !stall;
    assign accept  = in_ch.valid && !stall;
    assign process = a_valid_reg && !stall;

    mups_window #(.MAX_PATTERN(MAX_PATTERN)) u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .data_byte (in_ch.data_byte),
        .last_byte (in_ch.last_byte),
        .window    (window),
        .position  (position)
    );

    mups_match #(.MAX_PATTERN(MAX_PATTERN)) u_match
    (
        .window   (window),
        .position (position),
        .cfg      (cfg),
        .result   (match)
    );

    assign hit_now = match.len_ok && match.enough && match.hit;

    // Tally and first offset including the byte being processed now.
    always_comb
    begin
        tally_eff = tally_reg;
        first_eff = first_reg;
        if (hit_now)
        begin
            if (tally_reg == 2'd0)
                first_eff = position - mups_pkg::POS_W'(cfg.length);
            if (tally_reg != 2'd2)
                tally_eff = tally_reg + 2'd1;
        end
    end

    always_comb
    begin
        a_valid_next   = accept || stall;
        a_last_next    = accept ? in_ch.last_byte : a_last_reg;
        tally_next     = tally_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        status_next    = status_reg;
        offset_next    = offset_reg;

        if (process)
        begin
            if (a_last_reg)
            begin
                // End of buffer: report, then start over
                tally_next     = 2'd0;
                first_next     = '0;
                out_valid_next = 1'b1;
                offset_next    = '0;
                if (!match.len_ok || !match.enough)
                    status_next = mups_pkg::ST_BAD;
                else if (tally_eff == 2'd0)
                    status_next = mups_pkg::ST_NOT_FOUND;
                else if (tally_eff == 2'd2)
                    status_next = mups_pkg::ST_AMBIGUOUS;
                else
                begin
                    status_next = mups_pkg::ST_FOUND;
                    offset_next = first_eff;
                end
            end
            else
            begin
                tally_next = tally_eff;
                first_next = first_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            a_last_reg    <= 1'b0;
            tally_reg     <= 2'd0;
            first_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            a_last_reg    <= a_last_next;
            tally_reg     <= tally_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        offset_reg <= offset_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.scan_status  = status_reg;
    assign out_ch.match_offset = offset_reg;

endmodule

// ===== src/mups_checker.sv =====
`timescale 1ns / 1ps

module mups_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            in_last,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [1:0]                      out_status,
    input  logic [mups_pkg::POS_W-1:0]      out_offset
);

    // A result stuck in the output register keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_offset))
        else $error("result changed while stalled");

    // Offset is only reported for a unique match
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != mups_pkg::ST_FOUND) |-> out_offset == '0)
        else $error("nonzero offset without a unique match");

    // Input back-pressure only comes from an untaken result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a pending result");

    // A last byte taken at the input is followed by a valid result
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |-> ##2 out_valid)
        else $error("no result after last byte");

endmodule

bind masked_unique_pattern_scan mups_checker u_mups_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_last    (in_ch.last_byte),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.scan_status),
    .out_offset (out_ch.match_offset)
);
